FILE: design/tjm_pkg.sv
// Shared types, key map constants and helper functions for the touch to joypad mapper.
package tjm_pkg;

  // Field widths.
  localparam int unsigned COORD_W = 9;
  localparam int unsigned JOY_W   = 8;
  localparam int unsigned BIT_W   = 3;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned SUM_W   = SQ_W + 1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT  = 1'd1;

  // Layout codes.
  localparam logic LAYOUT_STD   = 1'b0;
  localparam logic LAYOUT_THREE = 1'b1;

  // Joypad bit positions (active low).
  localparam logic [BIT_W-1:0] BIT_A      = 3'd0;
  localparam logic [BIT_W-1:0] BIT_B      = 3'd1;
  localparam logic [BIT_W-1:0] BIT_SELECT = 3'd2;
  localparam logic [BIT_W-1:0] BIT_START  = 3'd3;
  localparam logic [BIT_W-1:0] BIT_RIGHT  = 3'd4;
  localparam logic [BIT_W-1:0] BIT_LEFT   = 3'd5;
  localparam logic [BIT_W-1:0] BIT_UP     = 3'd6;
  localparam logic [BIT_W-1:0] BIT_DOWN   = 3'd7;

  localparam logic [JOY_W-1:0] JOY_RELEASED = 8'hFF;

  // Virtual stick geometry.
  localparam logic [COORD_W-1:0] STICK_CX   = 9'd67;
  localparam logic [COORD_W-1:0] STICK_CY   = 9'd231;
  localparam logic [SUM_W-1:0]   STICK_R_SQ = 19'd400;
  localparam logic [COORD_W-1:0] STICK_MIN  = 9'd8;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [BIT_W-1:0]   bit_idx;
  } rect_t;

  localparam int unsigned NUM_THREE = 3;
  localparam int unsigned NUM_STD   = 8;

  localparam rect_t THREE_KEYS [NUM_THREE] = '{
    '{x0: 9'd34,  y0: 9'd200, x1: 9'd94,  y1: 9'd260, bit_idx: BIT_A},
    '{x0: 9'd330, y0: 9'd176, x1: 9'd390, y1: 9'd236, bit_idx: BIT_B},
    '{x0: 9'd282, y0: 9'd224, x1: 9'd342, y1: 9'd284, bit_idx: BIT_START}
  };

  localparam rect_t STD_KEYS [NUM_STD] = '{
    '{x0: 9'd47,  y0: 9'd167, x1: 9'd87,  y1: 9'd207, bit_idx: BIT_UP},
    '{x0: 9'd3,   y0: 9'd211, x1: 9'd43,  y1: 9'd251, bit_idx: BIT_LEFT},
    '{x0: 9'd91,  y0: 9'd211, x1: 9'd131, y1: 9'd251, bit_idx: BIT_RIGHT},
    '{x0: 9'd47,  y0: 9'd255, x1: 9'd87,  y1: 9'd294, bit_idx: BIT_DOWN},
    '{x0: 9'd336, y0: 9'd182, x1: 9'd384, y1: 9'd230, bit_idx: BIT_A},
    '{x0: 9'd288, y0: 9'd230, x1: 9'd336, y1: 9'd278, bit_idx: BIT_B},
    '{x0: 9'd140, y0: 9'd278, x1: 9'd196, y1: 9'd298, bit_idx: BIT_SELECT},
    '{x0: 9'd204, y0: 9'd278, x1: 9'd260, y1: 9'd298, bit_idx: BIT_START}
  };

  // Configuration seen by the decoder.
  typedef struct packed {
    logic enabled;
    logic layout_mode;
  } cfg_t;

  // One touch sample.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               down;
  } touch_t;

  // Decoder result.
  typedef struct packed {
    logic [JOY_W-1:0] joy;
    logic             latch;
  } result_t;

  // Inclusive rectangle test.
  function automatic logic rect_hit(rect_t r, logic [COORD_W-1:0] x,
                                    logic [COORD_W-1:0] y);
    return (x >= r.x0) && (x <= r.x1) && (y >= r.y0) && (y <= r.y1);
  endfunction

  // Right, left, up and down occupy the upper four bit positions.
  function automatic logic is_direction(logic [BIT_W-1:0] b);
    return (b == BIT_RIGHT) || (b == BIT_LEFT) || (b == BIT_UP) || (b == BIT_DOWN);
  endfunction

endpackage

FILE: design/touch_to_joypad_mapper.sv
// Top level of the touch to joypad mapper: configuration, latch and result register.
//
// Each touch item yields one joypad byte (active low) and the stick latch state.
// An item is registered on entry and decoded by fixed comparators and two 9-bit
// squarers into the result register, so one item is taken every cycle unless in_stall
// is high; its result goes from the input register through the result register to the
// outputs. The stick latch is updated as a result loads, so the next item always sees
// it. The input register can let a new item in while a result waits on out_stall.
// Configuration writes are always ready; clearing enabled also releases the stick latch.
module touch_to_joypad_mapper (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tjm_pkg::COORD_W-1:0]      in_touch_x,
  input  logic [tjm_pkg::COORD_W-1:0]      in_touch_y,
  input  logic                             in_touch_down,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tjm_pkg::JOY_W-1:0]        out_joypad_bits,
  output logic                             out_stick_held,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tjm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                             cfg_data
);

  tjm_pkg::touch_t  in_item;
  tjm_pkg::touch_t  item;
  tjm_pkg::result_t res;
  tjm_pkg::cfg_t    cfg;
  logic             item_valid;
  logic             advance;
  logic             cfg_we;

  logic                      enabled_r;
  logic                      layout_r;
  logic                      latch_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [tjm_pkg::JOY_W-1:0] joy_r;
  logic                      held_r;

  assign in_item = '{x: in_touch_x, y: in_touch_y, down: in_touch_down};
  assign cfg     = '{enabled: enabled_r, layout_mode: layout_r};

  // The result register takes a new item when empty or being drained.
  assign advance       = !out_valid_r || !out_stall;
  assign out_valid_nxt = advance ? item_valid : out_valid_r;

  tjm_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tjm_decode u_decode (
    .cfg       (cfg),
    .touch     (item),
    .latch_cur (latch_r),
    .res       (res)
  );

  // Configuration writes.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      layout_r  <= tjm_pkg::LAYOUT_STD;
    end else if (cfg_we) begin
      case (cfg_index)
        tjm_pkg::CFG_ENABLED: enabled_r <= cfg_data;
        tjm_pkg::CFG_LAYOUT:  layout_r  <= cfg_data;
        default:              ;
      endcase
    end
  end

  // Stick latch: follows each decoded item, cleared when the block is disabled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= 1'b0;
    end else if (cfg_we && (cfg_index == tjm_pkg::CFG_ENABLED) && !cfg_data) begin
      latch_r <= 1'b0;
    end else if (advance && item_valid) begin
      latch_r <= res.latch;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      joy_r  <= res.joy;
      held_r <= res.latch;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_joypad_bits = joy_r;
  assign out_stick_held  = held_r;

`ifndef SYNTHESIS
  // A lifted finger always gives a released pad and a cleared latch.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_valid && !item.down) |=>
      (out_joypad_bits == tjm_pkg::JOY_RELEASED) && !out_stick_held)
    else $error("lifted touch did not release the pad");

  // With the stick latched at most one direction is pressed.
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stick_held) |->
      ($countones(~out_joypad_bits[tjm_pkg::JOY_W-1:4]) <= 1))
    else $error("more than one direction pressed while stick latched");

  // A result waiting on the output never lets the input stage drop its item.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && item_valid) |=> item_valid)
    else $error("input stage lost an item while output stalled");
`endif

endmodule

FILE: design/tjm_in_stage.sv
// Input register stage that holds one touch item until the decoder takes it.
module tjm_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tjm_pkg::touch_t in_item,
  input  logic            advance,
  output logic            item_valid,
  output tjm_pkg::touch_t item
);

  logic            valid_r;
  logic            valid_nxt;
  tjm_pkg::touch_t item_r;

  // The stage is free when empty or when its item moves on this cycle.
  assign in_stall  = valid_r && !advance;
  assign valid_nxt = (in_valid && !in_stall) || (valid_r && !advance);

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads on each accepted item.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: design/tjm_decode.sv
// Combinational key decoder: virtual stick, key rectangles and latch update.
module tjm_decode (
  input  tjm_pkg::cfg_t    cfg,
  input  tjm_pkg::touch_t  touch,
  input  logic             latch_cur,
  output tjm_pkg::result_t res
);

  logic signed [tjm_pkg::DIFF_W-1:0]  dx;
  logic signed [tjm_pkg::DIFF_W-1:0]  dy;
  logic        [tjm_pkg::COORD_W-1:0] ax;
  logic        [tjm_pkg::COORD_W-1:0] ay;
  logic        [tjm_pkg::SQ_W-1:0]    sq_x;
  logic        [tjm_pkg::SQ_W-1:0]    sq_y;
  logic        [tjm_pkg::SUM_W-1:0]   dist_sq;
  logic                               in_circle;

  // Offsets from the stick center and their magnitudes.
  assign dx   = $signed({1'b0, touch.x}) - $signed({1'b0, tjm_pkg::STICK_CX});
  assign dy   = $signed({1'b0, touch.y}) - $signed({1'b0, tjm_pkg::STICK_CY});
  assign ax   = dx[tjm_pkg::DIFF_W-1] ? tjm_pkg::COORD_W'(-dx) : tjm_pkg::COORD_W'(dx);
  assign ay   = dy[tjm_pkg::DIFF_W-1] ? tjm_pkg::COORD_W'(-dy) : tjm_pkg::COORD_W'(dy);
  assign sq_x = ax * ax;
  assign sq_y = ay * ay;
  assign dist_sq   = {1'b0, sq_x} + {1'b0, sq_y};
  assign in_circle = (dist_sq <= tjm_pkg::STICK_R_SQ);

  // Key selection for the active layout.
  always_comb begin
    logic [tjm_pkg::JOY_W-1:0] j;
    logic                      l;
    j = tjm_pkg::JOY_RELEASED;
    l = latch_cur;
    if (!cfg.enabled || !touch.down) begin
      l = 1'b0;
    end else if (cfg.layout_mode == tjm_pkg::LAYOUT_THREE) begin
      for (int i = 0; i < tjm_pkg::NUM_THREE; i++) begin
        if (tjm_pkg::rect_hit(tjm_pkg::THREE_KEYS[i], touch.x, touch.y)) begin
          j[tjm_pkg::THREE_KEYS[i].bit_idx] = 1'b0;
        end
      end
    end else begin
      // The stick latches on entry and stays latched until release.
      if (latch_cur || in_circle) begin
        l = 1'b1;
        if ((ax >= tjm_pkg::STICK_MIN) || (ay >= tjm_pkg::STICK_MIN)) begin
          if (ax > ay) begin
            j[dx[tjm_pkg::DIFF_W-1] ? tjm_pkg::BIT_LEFT : tjm_pkg::BIT_RIGHT] = 1'b0;
          end else begin
            j[dy[tjm_pkg::DIFF_W-1] ? tjm_pkg::BIT_UP : tjm_pkg::BIT_DOWN] = 1'b0;
          end
        end
      end
      // Direction rectangles are ignored while the stick is latched.
      for (int i = 0; i < tjm_pkg::NUM_STD; i++) begin
        if (!(l && tjm_pkg::is_direction(tjm_pkg::STD_KEYS[i].bit_idx)) &&
            tjm_pkg::rect_hit(tjm_pkg::STD_KEYS[i], touch.x, touch.y)) begin
          j[tjm_pkg::STD_KEYS[i].bit_idx] = 1'b0;
        end
      end
    end
    res.joy   = j;
    res.latch = l;
  end

endmodule
